// File: rtl/zaf_pkg.sv
package zaf_pkg;

	// Operation codes carried in the action field.
	typedef enum logic [4:0] {
		ACT_ADD   = 5'd0,
		ACT_ADC   = 5'd1,
		ACT_SUB   = 5'd2,
		ACT_SBC   = 5'd3,
		ACT_AND   = 5'd4,
		ACT_XOR   = 5'd5,
		ACT_OR    = 5'd6,
		ACT_CP    = 5'd7,
		ACT_INC   = 5'd8,
		ACT_DEC   = 5'd9,
		ACT_NEG   = 5'd10,
		ACT_DAA   = 5'd11,
		ACT_CPL   = 5'd12,
		ACT_CCF   = 5'd13,
		ACT_SCF   = 5'd14,
		ACT_RLD   = 5'd15,
		ACT_RRD   = 5'd16,
		ACT_ADD16 = 5'd17,
		ACT_ADC16 = 5'd18,
		ACT_SBC16 = 5'd19
	} act_t;

	// Bit positions in the flag byte.
	localparam int unsigned FLAG_S  = 7;
	localparam int unsigned FLAG_Z  = 6;
	localparam int unsigned FLAG_F5 = 5;
	localparam int unsigned FLAG_H  = 4;
	localparam int unsigned FLAG_F3 = 3;
	localparam int unsigned FLAG_PV = 2;
	localparam int unsigned FLAG_N  = 1;
	localparam int unsigned FLAG_C  = 0;

	// Flag masks: sign, zero and parity kept; the two undocumented copy bits.
	localparam logic [7:0] FLAGS_SZPV = 8'hC4;
	localparam logic [7:0] FLAGS_XY   = 8'h28;

	// Decimal adjust constants.
	localparam logic [7:0] DAA_LIMIT  = 8'h99;
	localparam logic [7:0] DAA_LOW    = 8'h06;
	localparam logic [7:0] DAA_HIGH   = 8'h60;
	localparam logic [3:0] DAA_DIGIT  = 4'd9;

	// Values after the adder stage, handed to the flag stage.
	typedef struct packed {
		act_t        act;
		logic [7:0]  acc;
		logic [7:0]  flg;
		logic [7:0]  opb;
		logic [15:0] x;
		logic [15:0] y;
		logic [16:0] sum;
		logic [7:0]  lres;
		logic [7:0]  dig;
		logic        daa_c;
	} alu_s2_t;

	// One finished result beat.
	typedef struct packed {
		logic [15:0] result;
		logic [7:0]  flags;
		logic [7:0]  digit;
		logic        wr;
	} alu_res_t;

	// Assemble a flag byte from its eight bits.
	function automatic logic [7:0] pack_flags(input logic s, input logic z, input logic f5,
		input logic h, input logic f3, input logic pv, input logic n, input logic c);
		return {s, z, f5, h, f3, pv, n, c};
	endfunction

	// Sign, zero, copy bits and even parity of a byte.
	function automatic logic [7:0] szp(input logic [7:0] v);
		return pack_flags(v[7], (v == 8'h00), v[5], 1'b0, v[3], ~(^v), 1'b0, 1'b0);
	endfunction

endpackage

// File: rtl/zaf_if.sv
// Operation channel: one ALU operation per beat.
interface zaf_op_if;
	logic        valid;
	logic        ready;
	logic [4:0]  action;
	logic [7:0]  accumulator;
	logic [7:0]  flags_in;
	logic [15:0] operand;
	logic [15:0] pair_in;

	modport source (output valid, action, accumulator, flags_in, operand, pair_in,
		input ready);
	modport sink (input valid, action, accumulator, flags_in, operand, pair_in,
		output ready);
endinterface

// Result channel: one result per beat.
interface zaf_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] result;
	logic [7:0]  flags_out;
	logic [7:0]  digit_byte;
	logic        writes_result;

	modport source (output valid, result, flags_out, digit_byte, writes_result,
		input ready);
	modport sink (input valid, result, flags_out, digit_byte, writes_result,
		output ready);
endinterface

// File: rtl/zaf_operate.sv
// Decode and the shared 17-bit add/subtract unit, plus the logic and digit paths.
module zaf_operate (
	input  logic [4:0]       action,
	input  logic [7:0]       acc,
	input  logic [7:0]       flg,
	input  logic [15:0]      operand,
	input  logic [15:0]      pair,
	output zaf_pkg::alu_s2_t s2
);

	zaf_pkg::act_t act;
	logic [7:0]    b;
	logic [15:0]   x;
	logic [15:0]   y;
	logic          cin;
	logic          sub;
	logic          t_low;
	logic          t_high;
	logic [7:0]    t;
	logic [7:0]    lres;
	logic [7:0]    dig;

	assign act = zaf_pkg::act_t'(action);
	assign b   = operand[7:0];

	// Decimal adjust correction from the old accumulator and flags.
	assign t_low  = flg[zaf_pkg::FLAG_H] || (acc[3:0] > zaf_pkg::DAA_DIGIT);
	assign t_high = flg[zaf_pkg::FLAG_C] || (acc > zaf_pkg::DAA_LIMIT);
	assign t      = (t_low ? zaf_pkg::DAA_LOW : 8'h00) | (t_high ? zaf_pkg::DAA_HIGH : 8'h00);

	// Operand selection for the adder.
	always_comb begin
		x   = {8'h00, acc};
		y   = {8'h00, b};
		cin = 1'b0;
		sub = 1'b0;
		case (act)
			zaf_pkg::ACT_ADD: begin
			end
			zaf_pkg::ACT_ADC: begin
				cin = flg[zaf_pkg::FLAG_C];
			end
			zaf_pkg::ACT_SUB, zaf_pkg::ACT_CP: begin
				sub = 1'b1;
			end
			zaf_pkg::ACT_SBC: begin
				sub = 1'b1;
				cin = flg[zaf_pkg::FLAG_C];
			end
			zaf_pkg::ACT_INC: begin
				x = {8'h00, b};
				y = 16'h0001;
			end
			zaf_pkg::ACT_DEC: begin
				x   = {8'h00, b};
				y   = 16'h0001;
				sub = 1'b1;
			end
			zaf_pkg::ACT_NEG: begin
				x   = 16'h0000;
				y   = {8'h00, acc};
				sub = 1'b1;
			end
			zaf_pkg::ACT_DAA: begin
				y   = {8'h00, t};
				sub = flg[zaf_pkg::FLAG_N];
			end
			zaf_pkg::ACT_ADD16: begin
				x = pair;
				y = operand;
			end
			zaf_pkg::ACT_ADC16: begin
				x   = pair;
				y   = operand;
				cin = flg[zaf_pkg::FLAG_C];
			end
			zaf_pkg::ACT_SBC16: begin
				x   = pair;
				y   = operand;
				cin = flg[zaf_pkg::FLAG_C];
				sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Logic results and the byte that digit rotates write back.
	always_comb begin
		lres = acc;
		dig  = 8'h00;
		case (act)
			zaf_pkg::ACT_AND: lres = acc & b;
			zaf_pkg::ACT_XOR: lres = acc ^ b;
			zaf_pkg::ACT_OR:  lres = acc | b;
			zaf_pkg::ACT_CPL: lres = ~acc;
			zaf_pkg::ACT_RLD: begin
				lres = {acc[7:4], b[7:4]};
				dig  = {b[3:0], acc[3:0]};
			end
			zaf_pkg::ACT_RRD: begin
				lres = {acc[7:4], b[3:0]};
				dig  = {acc[3:0], b[7:4]};
			end
			default: begin
			end
		endcase
	end

	assign s2.act   = act;
	assign s2.acc   = acc;
	assign s2.flg   = flg;
	assign s2.opb   = b;
	assign s2.x     = x;
	assign s2.y     = y;
	assign s2.sum   = sub ? ({1'b0, x} - {1'b0, y} - {16'h0000, cin})
	                      : ({1'b0, x} + {1'b0, y} + {16'h0000, cin});
	assign s2.lres  = lres;
	assign s2.dig   = dig;
	assign s2.daa_c = t_high;

endmodule

// File: rtl/zaf_flags.sv
// Flag composition and result selection from the adder stage outputs.
module zaf_flags (
	input  zaf_pkg::alu_s2_t  s2,
	output zaf_pkg::alu_res_t res
);

	logic [7:0]  r8;
	logic [15:0] r16;
	logic [15:0] hx;
	logic        v8_add;
	logic        v8_sub;
	logic        v16_add;
	logic        v16_sub;
	logic        z8;
	logic        z16;
	logic        c_in;
	logic [7:0]  keep;
	logic [7:0]  fo;
	logic [7:0]  sub_f;

	assign r8      = s2.sum[7:0];
	assign r16     = s2.sum[15:0];
	assign hx      = s2.x ^ s2.y ^ r16;
	assign v8_add  = (s2.x[7] ^ ~s2.y[7]) & (s2.x[7] ^ s2.sum[7]);
	assign v8_sub  = (s2.x[7] ^ s2.y[7]) & (s2.x[7] ^ s2.sum[7]);
	assign v16_add = (s2.x[15] ^ ~s2.y[15]) & (s2.x[15] ^ s2.sum[15]);
	assign v16_sub = (s2.x[15] ^ s2.y[15]) & (s2.x[15] ^ s2.sum[15]);
	assign z8      = (r8 == 8'h00);
	assign z16     = (r16 == 16'h0000);
	assign c_in    = s2.flg[zaf_pkg::FLAG_C];
	assign keep    = s2.flg & zaf_pkg::FLAGS_SZPV;
	assign sub_f   = zaf_pkg::pack_flags(r8[7], z8, r8[5], hx[4], r8[3], v8_sub, 1'b1,
		s2.sum[8]);

	// New flag byte for each operation.
	always_comb begin
		case (s2.act)
			zaf_pkg::ACT_ADD, zaf_pkg::ACT_ADC:
				fo = zaf_pkg::pack_flags(r8[7], z8, r8[5], hx[4], r8[3], v8_add, 1'b0,
					s2.sum[8]);
			zaf_pkg::ACT_SUB, zaf_pkg::ACT_SBC, zaf_pkg::ACT_NEG:
				fo = sub_f;
			zaf_pkg::ACT_CP:
				fo = (sub_f & ~zaf_pkg::FLAGS_XY) | (s2.opb & zaf_pkg::FLAGS_XY);
			zaf_pkg::ACT_AND:
				fo = zaf_pkg::szp(s2.lres) | (8'h01 << zaf_pkg::FLAG_H);
			zaf_pkg::ACT_XOR, zaf_pkg::ACT_OR:
				fo = zaf_pkg::szp(s2.lres);
			zaf_pkg::ACT_INC:
				fo = zaf_pkg::pack_flags(r8[7], z8, r8[5], (r8[3:0] == 4'h0), r8[3],
					(r8 == 8'h80), 1'b0, c_in);
			zaf_pkg::ACT_DEC:
				fo = zaf_pkg::pack_flags(r8[7], z8, r8[5], (r8[3:0] == 4'hF), r8[3],
					(r8 == 8'h7F), 1'b1, c_in);
			zaf_pkg::ACT_DAA:
				fo = zaf_pkg::szp(r8) | zaf_pkg::pack_flags(1'b0, 1'b0, 1'b0,
					s2.acc[4] ^ r8[4], 1'b0, 1'b0, s2.flg[zaf_pkg::FLAG_N], s2.daa_c);
			zaf_pkg::ACT_CPL:
				fo = (s2.flg & (zaf_pkg::FLAGS_SZPV | 8'h01)) | (s2.lres & zaf_pkg::FLAGS_XY)
					| (8'h01 << zaf_pkg::FLAG_H) | (8'h01 << zaf_pkg::FLAG_N);
			zaf_pkg::ACT_CCF:
				fo = keep | (s2.acc & zaf_pkg::FLAGS_XY)
					| (c_in ? (8'h01 << zaf_pkg::FLAG_H) : 8'h01);
			zaf_pkg::ACT_SCF:
				fo = keep | (s2.acc & zaf_pkg::FLAGS_XY) | 8'h01;
			zaf_pkg::ACT_RLD, zaf_pkg::ACT_RRD:
				fo = zaf_pkg::szp(s2.lres) | {7'h00, c_in};
			zaf_pkg::ACT_ADD16:
				fo = keep | zaf_pkg::pack_flags(1'b0, 1'b0, r16[13], hx[12], r16[11], 1'b0,
					1'b0, s2.sum[16]);
			zaf_pkg::ACT_ADC16:
				fo = zaf_pkg::pack_flags(r16[15], z16, r16[13], hx[12], r16[11], v16_add,
					1'b0, s2.sum[16]);
			zaf_pkg::ACT_SBC16:
				fo = zaf_pkg::pack_flags(r16[15], z16, r16[13], hx[12], r16[11], v16_sub,
					1'b1, s2.sum[16]);
			default:
				fo = s2.flg;
		endcase
	end

	// Result word and write-enable for each operation.
	always_comb begin
		res.flags = fo;
		res.digit = s2.dig;
		case (s2.act)
			zaf_pkg::ACT_ADD, zaf_pkg::ACT_ADC, zaf_pkg::ACT_SUB, zaf_pkg::ACT_SBC,
			zaf_pkg::ACT_INC, zaf_pkg::ACT_DEC, zaf_pkg::ACT_NEG, zaf_pkg::ACT_DAA: begin
				res.result = {8'h00, r8};
				res.wr     = 1'b1;
			end
			zaf_pkg::ACT_AND, zaf_pkg::ACT_XOR, zaf_pkg::ACT_OR, zaf_pkg::ACT_CPL,
			zaf_pkg::ACT_RLD, zaf_pkg::ACT_RRD: begin
				res.result = {8'h00, s2.lres};
				res.wr     = 1'b1;
			end
			zaf_pkg::ACT_ADD16, zaf_pkg::ACT_ADC16, zaf_pkg::ACT_SBC16: begin
				res.result = r16;
				res.wr     = 1'b1;
			end
			default: begin
				res.result = {8'h00, s2.acc};
				res.wr     = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/z80_alu_flags.sv
// Z80 ALU with flag generation. One operation is accepted on every clock in which
// op_ch.ready is high, and its result appears on res_ch from the output register.
// There are three register stages: the input register, the register after the
// single 17-bit add/subtract unit shared by all arithmetic operations, and the
// output register after the flag and result selection. Throughput is one
// operation per cycle; when res_ch.ready is low the stages fill up and op_ch.ready
// drops once all three hold a beat.
module z80_alu_flags (
	input  logic        clk,
	input  logic        arst_n,
	zaf_op_if.sink      op_ch,
	zaf_res_if.source   res_ch
);

	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              en1;
	logic              en2;
	logic              en3;
	logic [4:0]        action_s1;
	logic [7:0]        acc_s1;
	logic [7:0]        flg_s1;
	logic [15:0]       operand_s1;
	logic [15:0]       pair_s1;
	zaf_pkg::alu_s2_t  s2_next;
	zaf_pkg::alu_s2_t  data_s2;
	zaf_pkg::alu_res_t res_next;
	zaf_pkg::alu_res_t data_s3;

	// A stage advances when the one after it is empty or advancing.
	assign en3         = !valid_s3 || res_ch.ready;
	assign en2         = !valid_s2 || en3;
	assign en1         = !valid_s1 || en2;
	assign op_ch.ready = en1;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= op_ch.valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	// Input register stage.
	always_ff @(posedge clk) begin
		if (en1) begin
			action_s1  <= op_ch.action;
			acc_s1     <= op_ch.accumulator;
			flg_s1     <= op_ch.flags_in;
			operand_s1 <= op_ch.operand;
			pair_s1    <= op_ch.pair_in;
		end
	end

	zaf_operate u_operate (
		.action  (action_s1),
		.acc     (acc_s1),
		.flg     (flg_s1),
		.operand (operand_s1),
		.pair    (pair_s1),
		.s2      (s2_next)
	);

	// Adder stage register.
	always_ff @(posedge clk) begin
		if (en2) data_s2 <= s2_next;
	end

	zaf_flags u_flags (
		.s2  (data_s2),
		.res (res_next)
	);

	// Output register stage.
	always_ff @(posedge clk) begin
		if (en3) data_s3 <= res_next;
	end

	assign res_ch.valid         = valid_s3;
	assign res_ch.result        = data_s3.result;
	assign res_ch.flags_out     = data_s3.flags;
	assign res_ch.digit_byte    = data_s3.digit;
	assign res_ch.writes_result = data_s3.wr;

	// A beat taken at the input sits in the first stage on the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(op_ch.valid && op_ch.ready) |=> valid_s1)
		else $error("accepted beat did not reach the first stage");

	// A held first stage keeps its operation.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !en2) |=> (valid_s1 && $stable(action_s1) && $stable(operand_s1)))
		else $error("first stage changed while stalled");

	// A held adder stage keeps its sum.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !en3) |=> (valid_s2 && $stable(data_s2)))
		else $error("adder stage changed while stalled");

	// Only digit rotates produce a memory byte, and they always write back.
	a_digit_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (data_s3.digit != 8'h00)) |-> data_s3.wr)
		else $error("digit byte without write-back");

endmodule

// File: tb/z80_alu_flags_checker.sv
// Watches both channels of the ALU, works out the result of every accepted
// operation and compares it with the result beats in order.
module z80_alu_flags_checker (
	input  logic        clk,
	input  logic        arst_n,
	zaf_op_if           op_ch,
	zaf_res_if          res_ch,
	output int unsigned fail_count,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Printing stops here; counting goes on.
	localparam int unsigned PRINT_CAP = 200;

	zaf_pkg::alu_res_t expected_q[$];
	int unsigned       beat_index;

	initial begin
		fail_count = 0;
		pending    = 0;
		beat_index = 0;
	end

	// Sign, zero, copy bits and even parity of a byte; H, N and C are left clear.
	function automatic logic [7:0] byte_flags(input logic [7:0] v);
		return {v[7], v == 8'h00, v[5], 1'b0, v[3], ~(^v), 2'b00};
	endfunction

	// 8-bit add or subtract with carry in; returns {flags, result}.
	function automatic logic [15:0] arith8(input logic [7:0] x, input logic [7:0] y,
		input logic cy, input logic sub);
		logic [8:0] r;
		logic [7:0] carries;
		logic       ovf;
		r = sub ? ({1'b0, x} - {1'b0, y} - cy) : ({1'b0, x} + {1'b0, y} + cy);
		carries = x ^ y ^ r[7:0];
		ovf = sub ? ((x[7] ^ y[7]) & (x[7] ^ r[7])) : (~(x[7] ^ y[7]) & (x[7] ^ r[7]));
		return {r[7], r[7:0] == 8'h00, r[5], carries[4], r[3], ovf, sub, r[8], r[7:0]};
	endfunction

	// Expected result beat for one operation.
	function automatic zaf_pkg::alu_res_t alu_predict(input logic [4:0] code,
		input logic [7:0] a, input logic [7:0] f, input logic [15:0] op,
		input logic [15:0] hl);
		zaf_pkg::alu_res_t o;
		logic [7:0]  b;
		logic [7:0]  r8;
		logic [7:0]  adj;
		logic [7:0]  bf;
		logic [15:0] t16;
		logic [16:0] r17;
		logic [15:0] x16;
		logic        cin;
		logic        ovf;
		b   = op[7:0];
		cin = f[zaf_pkg::FLAG_C];
		o.result = {8'h00, a};
		o.flags  = f;
		o.digit  = 8'h00;
		o.wr     = 1'b1;
		case (code)
			zaf_pkg::ACT_ADD, zaf_pkg::ACT_ADC, zaf_pkg::ACT_SUB, zaf_pkg::ACT_SBC: begin
				t16 = arith8(a, b,
					(code == zaf_pkg::ACT_ADC || code == zaf_pkg::ACT_SBC) ? cin : 1'b0,
					(code == zaf_pkg::ACT_SUB || code == zaf_pkg::ACT_SBC));
				o.result = {8'h00, t16[7:0]};
				o.flags  = t16[15:8];
			end
			zaf_pkg::ACT_AND: begin
				bf = byte_flags(a & b);
				bf[zaf_pkg::FLAG_H] = 1'b1;
				o.result = {8'h00, a & b};
				o.flags  = bf;
			end
			zaf_pkg::ACT_XOR: begin
				o.result = {8'h00, a ^ b};
				o.flags  = byte_flags(a ^ b);
			end
			zaf_pkg::ACT_OR: begin
				o.result = {8'h00, a | b};
				o.flags  = byte_flags(a | b);
			end
			// Compare takes its copy bits from the operand and writes nothing.
			zaf_pkg::ACT_CP: begin
				t16 = arith8(a, b, 1'b0, 1'b1);
				o.flags = {t16[15:14], b[5], t16[12], b[3], t16[10:8]};
				o.wr    = 1'b0;
			end
			zaf_pkg::ACT_INC: begin
				r8 = b + 8'd1;
				o.result = {8'h00, r8};
				o.flags  = {r8[7], r8 == 8'h00, r8[5], r8[3:0] == 4'h0, r8[3],
					r8 == 8'h80, 1'b0, cin};
			end
			zaf_pkg::ACT_DEC: begin
				r8 = b - 8'd1;
				o.result = {8'h00, r8};
				o.flags  = {r8[7], r8 == 8'h00, r8[5], r8[3:0] == 4'hF, r8[3],
					r8 == 8'h7F, 1'b1, cin};
			end
			zaf_pkg::ACT_NEG: begin
				t16 = arith8(8'h00, a, 1'b0, 1'b1);
				o.result = {8'h00, t16[7:0]};
				o.flags  = t16[15:8];
			end
			// Decimal adjust: H comes from bit 4 of old XOR new accumulator.
			zaf_pkg::ACT_DAA: begin
				adj = 8'h00;
				if (f[zaf_pkg::FLAG_H] || a[3:0] > zaf_pkg::DAA_DIGIT)
					adj = adj | zaf_pkg::DAA_LOW;
				if (cin || a > zaf_pkg::DAA_LIMIT)
					adj = adj | zaf_pkg::DAA_HIGH;
				r8 = f[zaf_pkg::FLAG_N] ? a - adj : a + adj;
				bf = byte_flags(r8);
				o.result = {8'h00, r8};
				o.flags  = {bf[7:5], a[4] ^ r8[4], bf[3:2], f[zaf_pkg::FLAG_N],
					adj >= zaf_pkg::DAA_HIGH};
			end
			zaf_pkg::ACT_CPL: begin
				r8 = ~a;
				o.result = {8'h00, r8};
				o.flags  = {f[zaf_pkg::FLAG_S], f[zaf_pkg::FLAG_Z], r8[5], 1'b1, r8[3],
					f[zaf_pkg::FLAG_PV], 1'b1, f[zaf_pkg::FLAG_C]};
			end
			zaf_pkg::ACT_CCF: begin
				o.flags = {f[zaf_pkg::FLAG_S], f[zaf_pkg::FLAG_Z], a[5], cin, a[3],
					f[zaf_pkg::FLAG_PV], 1'b0, ~cin};
				o.wr    = 1'b0;
			end
			zaf_pkg::ACT_SCF: begin
				o.flags = {f[zaf_pkg::FLAG_S], f[zaf_pkg::FLAG_Z], a[5], 1'b0, a[3],
					f[zaf_pkg::FLAG_PV], 1'b0, 1'b1};
				o.wr    = 1'b0;
			end
			// Digit rotates keep C and clear H and N.
			zaf_pkg::ACT_RLD: begin
				r8 = {a[7:4], b[7:4]};
				o.result = {8'h00, r8};
				o.digit  = {b[3:0], a[3:0]};
				o.flags  = byte_flags(r8) | {7'b0, cin};
			end
			zaf_pkg::ACT_RRD: begin
				r8 = {a[7:4], b[3:0]};
				o.result = {8'h00, r8};
				o.digit  = {a[3:0], b[7:4]};
				o.flags  = byte_flags(r8) | {7'b0, cin};
			end
			// The plain 16-bit add keeps S, Z and PV; H is the carry out of bit 11.
			zaf_pkg::ACT_ADD16: begin
				r17 = {1'b0, hl} + {1'b0, op};
				x16 = hl ^ op ^ r17[15:0];
				o.result = r17[15:0];
				o.flags  = {f[zaf_pkg::FLAG_S], f[zaf_pkg::FLAG_Z], r17[13], x16[12],
					r17[11], f[zaf_pkg::FLAG_PV], 1'b0, r17[16]};
			end
			zaf_pkg::ACT_ADC16, zaf_pkg::ACT_SBC16: begin
				if (code == zaf_pkg::ACT_ADC16) begin
					r17 = {1'b0, hl} + {1'b0, op} + cin;
					ovf = ~(hl[15] ^ op[15]) & (hl[15] ^ r17[15]);
				end else begin
					r17 = {1'b0, hl} - {1'b0, op} - cin;
					ovf = (hl[15] ^ op[15]) & (hl[15] ^ r17[15]);
				end
				x16 = hl ^ op ^ r17[15:0];
				o.result = r17[15:0];
				o.flags  = {r17[15], r17[15:0] == 16'h0000, r17[13], x16[12], r17[11], ovf,
					code == zaf_pkg::ACT_SBC16, r17[16]};
			end
			// Codes past the last operation leave everything as it was.
			default: begin
				o.wr = 1'b0;
			end
		endcase
		return o;
	endfunction

	// Prints one line per mismatch, up to PRINT_CAP lines, and counts every one.
	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_CAP)
			$display("ERROR at %0t ns: %s", $realtime, msg);
		fail_count = fail_count + 1;
	endtask

	// Check result beats against the oldest prediction, then queue new ones.
	always @(posedge clk) begin
		zaf_pkg::alu_res_t exp_res;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result beat %0d with nothing outstanding",
						beat_index));
				end else begin
					exp_res = expected_q.pop_front();
					if (res_ch.result !== exp_res.result)
						report_mismatch($sformatf("beat %0d result %h, expected %h",
							beat_index, res_ch.result, exp_res.result));
					if (res_ch.flags_out !== exp_res.flags)
						report_mismatch($sformatf("beat %0d flags %b, expected %b",
							beat_index, res_ch.flags_out, exp_res.flags));
					if (res_ch.digit_byte !== exp_res.digit)
						report_mismatch($sformatf("beat %0d digit byte %h, expected %h",
							beat_index, res_ch.digit_byte, exp_res.digit));
					if (res_ch.writes_result !== exp_res.wr)
						report_mismatch($sformatf("beat %0d write enable %b, expected %b",
							beat_index, res_ch.writes_result, exp_res.wr));
				end
				beat_index = beat_index + 1;
			end
			if (op_ch.valid && op_ch.ready)
				expected_q.push_back(alu_predict(op_ch.action, op_ch.accumulator,
					op_ch.flags_in, op_ch.operand, op_ch.pair_in));
			pending <= expected_q.size();
		end
	end

endmodule

// File: tb/z80_alu_flags_test.sv
// Drives operations into the ALU with random gaps and result stalls, and
// gives the verdict from the checker's failure count.
module z80_alu_flags_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_OPS     = 530;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned LONG_HOLD      = 60;
	localparam int unsigned HOLD_AFTER     = 200;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam logic [4:0]  ACT_NONE_LAST  = 5'd31;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned quiet_cycles = 0;
	logic        rx_hold = 1'b0;
	logic        op_burst = 1'b0;
	logic        res_burst = 1'b0;

	zaf_op_if  op_ch ();
	zaf_res_if res_ch ();

	z80_alu_flags DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.op_ch  (op_ch),
		.res_ch (res_ch)
	);

	z80_alu_flags_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_ch      (op_ch),
		.res_ch     (res_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	// Corner values half the time, otherwise anything.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h7F;
			3: return 8'h80;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offers one operation beat after a random gap and waits until it is taken.
	task automatic send_op(input logic [4:0] code, input logic [7:0] a, input logic [7:0] f,
		input logic [15:0] op, input logic [15:0] hl);
		int unsigned gap;
		gap = (rx_hold || op_burst) ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap > 0) begin
			op_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op_ch.action      <= code;
		op_ch.accumulator <= a;
		op_ch.flags_in    <= f;
		op_ch.operand     <= op;
		op_ch.pair_in     <= hl;
		op_ch.valid       <= 1'b1;
		do @(posedge clk); while (!op_ch.ready);
	endtask

	task automatic send_random();
		logic [4:0] code;
		if ($urandom_range(0, 19) == 0)
			code = 5'($urandom_range(20, 31));
		else
			code = 5'($urandom_range(0, 19));
		send_op(code, pick_byte(), pick_byte(), {pick_byte(), pick_byte()},
			{pick_byte(), pick_byte()});
	endtask

	// Stops offering beats until every outstanding result has come back.
	task automatic wait_drained();
		@(negedge clk);
		op_ch.valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
	endtask

	// Stimulus and verdict.
	initial begin
		op_ch.valid       = 1'b0;
		op_ch.action      = zaf_pkg::ACT_ADD;
		op_ch.accumulator = 8'h00;
		op_ch.flags_in    = 8'h00;
		op_ch.operand     = 16'h0000;
		op_ch.pair_in     = 16'h0000;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed corners: carries, overflows, zero results and every operation.
		send_op(zaf_pkg::ACT_ADD,   8'hFF, 8'h00, 16'h0001, 16'h0000);
		send_op(zaf_pkg::ACT_ADD,   8'h7F, 8'hFF, 16'hFF01, 16'hFFFF);
		send_op(zaf_pkg::ACT_ADC,   8'hFF, 8'h01, 16'hFF00, 16'h0000);
		send_op(zaf_pkg::ACT_SUB,   8'h80, 8'h00, 16'h0001, 16'h0000);
		send_op(zaf_pkg::ACT_SBC,   8'h00, 8'h01, 16'h0000, 16'h0000);
		send_op(zaf_pkg::ACT_AND,   8'hFF, 8'h00, 16'h00FF, 16'h0000);
		send_op(zaf_pkg::ACT_XOR,   8'hAA, 8'hFF, 16'h0055, 16'h0000);
		send_op(zaf_pkg::ACT_OR,    8'h00, 8'hFF, 16'hFF00, 16'h0000);
		send_op(zaf_pkg::ACT_CP,    8'h10, 8'h00, 16'h0028, 16'h0000);
		send_op(zaf_pkg::ACT_INC,   8'h00, 8'h01, 16'h007F, 16'h0000);
		send_op(zaf_pkg::ACT_INC,   8'h00, 8'h00, 16'h00FF, 16'h0000);
		send_op(zaf_pkg::ACT_DEC,   8'h00, 8'h01, 16'h0080, 16'h0000);
		send_op(zaf_pkg::ACT_DEC,   8'h00, 8'h00, 16'h0000, 16'h0000);
		send_op(zaf_pkg::ACT_NEG,   8'h80, 8'h00, 16'h0000, 16'h0000);
		send_op(zaf_pkg::ACT_NEG,   8'h00, 8'hFF, 16'h0000, 16'h0000);
		send_op(zaf_pkg::ACT_DAA,   8'h9A, 8'h00, 16'h0000, 16'h0000);
		send_op(zaf_pkg::ACT_DAA,   8'h0F, 8'h12, 16'h0000, 16'h0000);
		send_op(zaf_pkg::ACT_CPL,   8'h5A, 8'hFF, 16'h0000, 16'h0000);
		send_op(zaf_pkg::ACT_CCF,   8'h28, 8'h01, 16'h0000, 16'h0000);
		send_op(zaf_pkg::ACT_SCF,   8'hD7, 8'h00, 16'h0000, 16'h0000);
		send_op(zaf_pkg::ACT_RLD,   8'h12, 8'h01, 16'hFF34, 16'h0000);
		send_op(zaf_pkg::ACT_RRD,   8'hFF, 8'h00, 16'h00A5, 16'h0000);
		send_op(zaf_pkg::ACT_ADD16, 8'h00, 8'hC4, 16'h0001, 16'h0FFF);
		send_op(zaf_pkg::ACT_ADC16, 8'h00, 8'h01, 16'h0000, 16'hFFFF);
		send_op(zaf_pkg::ACT_SBC16, 8'h00, 8'h00, 16'h0001, 16'h8000);
		send_op(ACT_NONE_LAST, 8'h3C, 8'hA5, 16'hFFFF, 16'hFFFF);
		wait_drained();

		// Random operations, with a full drain halfway through.
		for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
			if (i % 32 == 0)
				op_burst = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_OPS / 2)
				wait_drained();
			send_random();
		end
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Result side: random stalls, one long hold-off to fill the pipeline.
	initial begin
		int unsigned stall;
		int unsigned taken;
		bit          held;
		res_ch.ready = 1'b0;
		taken = 0;
		held  = 0;
		wait (arst_n);
		forever begin
			if (taken % 32 == 0)
				res_burst = ($urandom_range(0, 3) == 0);
			@(negedge clk);
			if (!held && taken >= HOLD_AFTER) begin
				held = 1;
				stall = LONG_HOLD;
				rx_hold = 1'b1;
			end else begin
				stall = res_burst ? 0 : $urandom_range(0, 13);
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rx_hold = 1'b0;
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			taken = taken + 1;
		end
	end

	// Ends the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

endmodule
